/* rtl/chdg_pkg.sv */
// ----------------------------------------------------------------------------
// chdg_pkg
// Shared constants for the compass heading CORDIC pipeline: fixed-point
// formats, the degree-scaled arctangent table and the output wrap limits.
// ----------------------------------------------------------------------------
package chdg_pkg;

  // Default configuration of the top level.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;

  // Guard bits appended below the sample before the iterations start.
  localparam int GUARD_BITS = 8;

  // Angle accumulator: signed, units of 2^-16 degree.
  localparam int ZW        = 26;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] Z_DEG90    = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] Z_NEG_DEG90 = -Z_DEG90;
  // Half an output LSB, with and without a full turn folded in.
  localparam logic signed [ZW-1:0] Z_ROUND_POS = ZW'(512);
  localparam logic signed [ZW-1:0] Z_ROUND_NEG = ZW'(360 * 65536 + 512);
  localparam int ROUND_SHIFT = 10;

  // Heading output: 1/64 degree.
  localparam int             HEAD_W    = 15;
  localparam logic [HEAD_W-1:0] FULL_TURN = HEAD_W'(23040);

  // Entry i is round(atan(2^-i) in degrees * 65536).
  localparam logic [ZW-1:0] ANGLE_TAB [TABLE_LEN] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
    ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
    ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
    ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
    ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
    ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
  };

endpackage

/* rtl/compass_heading_atan2_unit.sv */
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit
// Pipelined CORDIC vectoring unit that turns a magnetometer X/Y sample into
// a compass heading in 1/64 degree, wrapped into 0 up to under 360 degrees.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_x_field, in_y_field) takes one
//   signed X/Y sample word. The result channel (out_valid, out_ready,
//   out_heading) returns one heading word per sample, in order.
//   The pipeline holds one pre-rotation stage, one register stage per CORDIC
//   micro-rotation (capped at 24) and one wrap-and-round output stage.
//   Throughput is one sample per clock while the output is not stalled;
//   every stage is a register with its own valid bit, and one add per
//   coordinate sets the stage depth.
//   When out_ready is low the output word holds; stages behind it keep
//   filling empty slots, so in_ready drops only when every stage is full.
//   A synchronous reset on rst_n empties the pipeline; data in flight is
//   dropped. A zero sample yields a heading of 0.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit #(
  parameter int CORDIC_STEPS = chdg_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = chdg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      in_x_field,
  input  logic signed [SAMPLE_BITS-1:0]      in_y_field,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [chdg_pkg::HEAD_W-1:0] out_heading
);
  import chdg_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  // Headroom for the half-plane fold and the CORDIC gain.
  localparam int W = SAMPLE_BITS + GUARD_BITS + 3;

  logic                 vld   [NSTEP+1];
  logic                 rdy   [NSTEP+1];
  logic signed [W-1:0]  xv    [NSTEP+1];
  logic signed [W-1:0]  yv    [NSTEP+1];
  logic signed [ZW-1:0] zv    [NSTEP+1];
  logic                 zero  [NSTEP+1];

  chdg_prerot #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .W           (W)
  ) u_prerot (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .x_i     (in_x_field),
    .y_i     (in_y_field),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .x_o     (xv[0]),
    .y_o     (yv[0]),
    .z_o     (zv[0]),
    .zero_o  (zero[0])
  );

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    chdg_cordic_stage #(
      .W    (W),
      .STEP (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .x_i     (xv[k]),
      .y_i     (yv[k]),
      .z_i     (zv[k]),
      .zero_i  (zero[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .x_o     (xv[k+1]),
      .y_o     (yv[k+1]),
      .z_o     (zv[k+1]),
      .zero_o  (zero[k+1])
    );
  end

  chdg_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (vld[NSTEP]),
    .ready_o   (rdy[NSTEP]),
    .z_i       (zv[NSTEP]),
    .zero_i    (zero[NSTEP]),
    .valid_o   (out_valid),
    .ready_i   (out_ready),
    .heading_o (out_heading)
  );

  // The final x and y magnitudes are not needed for the heading.
  logic unused_xy;
  assign unused_xy = ^{xv[NSTEP], yv[NSTEP]};

endmodule

/* rtl/chdg_prerot.sv */
// ----------------------------------------------------------------------------
// chdg_prerot
// Entry stage: sign extends and scales the sample, folds the left half
// plane onto the right half plane and seeds the angle accumulator.
// ----------------------------------------------------------------------------
module chdg_prerot #(
  parameter int SAMPLE_BITS = 16,
  parameter int W           = 27
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       x_i,
  input  logic signed [SAMPLE_BITS-1:0]       y_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [W-1:0]                 x_o,
  output logic signed [W-1:0]                 y_o,
  output logic signed [chdg_pkg::ZW-1:0]      z_o,
  output logic                                zero_o
);
  import chdg_pkg::*;

  logic                 vld_r;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 zero_r, zero_nxt;
  logic signed [W-1:0]  xs, ys;

  assign ready_o = !vld_r || ready_i;

  always_comb begin
    xs       = W'(x_i) <<< GUARD_BITS;
    ys       = W'(y_i) <<< GUARD_BITS;
    zero_nxt = (x_i == '0) && (y_i == '0);
    x_nxt    = xs;
    y_nxt    = ys;
    z_nxt    = '0;
    // Rotate by -90 or +90 degrees so that x is never negative.
    if (xs[W-1]) begin
      if (!ys[W-1]) begin
        x_nxt = ys;
        y_nxt = -xs;
        z_nxt = Z_DEG90;
      end else begin
        x_nxt = -ys;
        y_nxt = xs;
        z_nxt = Z_NEG_DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign valid_o = vld_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign zero_o  = zero_r;

endmodule

/* rtl/chdg_cordic_stage.sv */
// ----------------------------------------------------------------------------
// chdg_cordic_stage
// One registered CORDIC vectoring micro-rotation, driving y toward zero and
// accumulating the rotated angle in degrees.
// ----------------------------------------------------------------------------
module chdg_cordic_stage #(
  parameter int W    = 27,
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [W-1:0]            x_i,
  input  logic signed [W-1:0]            y_i,
  input  logic signed [chdg_pkg::ZW-1:0] z_i,
  input  logic                           zero_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [chdg_pkg::ZW-1:0] z_o,
  output logic                           zero_o
);
  import chdg_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ANGLE_TAB[STEP];

  logic                 vld_r;
  logic signed [W-1:0]  x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 zero_r;
  logic signed [W-1:0]  dx, dy;

  assign ready_o = !vld_r || ready_i;

  // Arithmetic shifts round toward minus infinity.
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (!y_i[W-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANGLE;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign valid_o = vld_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign zero_o  = zero_r;

endmodule

/* rtl/chdg_round.sv */
// ----------------------------------------------------------------------------
// chdg_round
// Output stage: wraps negative angles by a full turn, rounds to 1/64 degree
// and holds the finished heading word for the receiver.
// ----------------------------------------------------------------------------
module chdg_round (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [chdg_pkg::ZW-1:0]     z_i,
  input  logic                               zero_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic        [chdg_pkg::HEAD_W-1:0] heading_o
);
  import chdg_pkg::*;

  logic                 vld_r;
  logic [HEAD_W-1:0]    head_r, head_nxt;
  logic signed [ZW-1:0] zr;
  logic [HEAD_W-1:0]    h;

  assign ready_o = !vld_r || ready_i;

  // The full-turn wrap and the rounding half are folded into one addend.
  assign zr = z_i + (z_i[ZW-1] ? Z_ROUND_NEG : Z_ROUND_POS);
  assign h  = zr[ROUND_SHIFT +: HEAD_W];

  always_comb begin
    head_nxt = h;
    if (zero_i || (h >= FULL_TURN)) begin
      head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      head_r <= head_nxt;
    end
  end

  assign valid_o   = vld_r;
  assign heading_o = head_r;

endmodule

/* tb/compass_heading_atan2_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit_tb
// Drives magnetometer X/Y sample words into the CORDIC heading unit and checks
// every heading word against a bit-exact fixed-point model kept in the bench.
// Directed corner samples run first, then random samples in several
// throttling phases on both channels.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit_tb;
  import chdg_pkg::*;

  localparam int  ROTATIONS  = 16;
  localparam int  ATAN_TAB_N = 24;
  localparam longint ONE_DEG = 65536;
  localparam longint WRAP_HEADING = 23040;

  // atan(2^-i) in units of 2^-16 degree.
  localparam longint ATAN_DEG_TAB [ATAN_TAB_N] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    logic signed [15:0] x_field;
    logic signed [15:0] y_field;
  } mag_sample_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [15:0]       in_x_field;
  logic signed [15:0]       in_y_field;
  logic                     out_valid;
  logic                     out_ready;
  logic        [HEAD_W-1:0] out_heading;

  mag_sample_t       sample_queue[$];
  logic [HEAD_W-1:0] heading_queue[$];
  bit                presenting;
  bit                failed;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;

  compass_heading_atan2_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x_field (in_x_field),
    .in_y_field (in_y_field),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_heading(out_heading)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Vectoring-mode CORDIC: rotate the vector onto the positive X axis and
  // accumulate the rotation in 2^-16 degree, then round to 1/64 degree.
  function automatic logic [HEAD_W-1:0] heading_for(input logic signed [15:0] xf,
                                                   input logic signed [15:0] yf);
    longint vx, vy, ang, dx, dy, swap, code;
    int     i;
    if (xf == 0 && yf == 0) return '0;
    vx = xf;
    vy = yf;
    vx = vx * 256;
    vy = vy * 256;
    ang = 0;
    if (vx < 0) begin
      swap = vx;
      if (vy >= 0) begin
        vx  = vy;
        vy  = -swap;
        ang = 90 * ONE_DEG;
      end else begin
        vx  = -vy;
        vy  = swap;
        ang = -90 * ONE_DEG;
      end
    end
    for (i = 0; i < ROTATIONS && i < ATAN_TAB_N; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        ang = ang + ATAN_DEG_TAB[i];
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        ang = ang - ATAN_DEG_TAB[i];
      end
    end
    if (ang < 0) ang = ang + 360 * ONE_DEG;
    if (ang < 0) ang = 0;
    code = (ang + 512) >>> 10;
    if (code >= WRAP_HEADING) code = 0;
    return code[HEAD_W-1:0];
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic queue_sample(input int xv, input int yv);
    mag_sample_t s;
    s.x_field = clip16(xv);
    s.y_field = clip16(yv);
    sample_queue.push_back(s);
  endtask

  task automatic queue_random_sample();
    int xv, yv, pick, extremes[6];
    extremes = '{-32768, -32767, -1, 0, 1, 32767};
    pick = $urandom_range(7);
    case (pick)
      0, 1: begin
        xv = $signed(16'($urandom));
        yv = $signed(16'($urandom));
      end
      2: begin
        xv = $urandom_range(128) - 64;
        yv = $urandom_range(128) - 64;
      end
      3: begin
        // One component near zero: headings close to the quadrant borders.
        xv = $signed(16'($urandom));
        yv = $urandom_range(8) - 4;
        if ($urandom_range(1)) begin
          pick = xv;
          xv   = yv;
          yv   = pick;
        end
      end
      4: begin
        xv = extremes[$urandom_range(5)];
        yv = extremes[$urandom_range(5)];
      end
      5: begin
        xv = $signed(16'($urandom));
        yv = ($urandom_range(1) ? xv : -xv) + int'($urandom_range(6)) - 3;
      end
      6: begin
        // Just below the positive X axis, where the heading lies just under a
        // full turn and can round up to it and wrap to zero.
        xv = $urandom_range(32767, 1000);
        yv = -int'($urandom_range(6, 1));
      end
      default: begin
        xv = $signed(16'($urandom)) >>> $urandom_range(15);
        yv = $signed(16'($urandom)) >>> $urandom_range(15);
      end
    endcase
    queue_sample(xv, yv);
  endtask

  // Sender: a word stays on the bus until the monitor sees it taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!presenting) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_x_field <= sample_queue[0].x_field;
          in_y_field <= sample_queue[0].y_field;
          presenting = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        heading_queue.push_back(heading_for(in_x_field, in_y_field));
        void'(sample_queue.pop_front());
        presenting = 1'b0;
      end
      if (out_valid && out_ready) begin
        if (heading_queue.size() == 0) begin
          $error("unexpected heading word: heading actual %0d", out_heading);
          failed = 1'b1;
        end else begin
          if (out_heading !== heading_queue[0]) begin
            $error("heading mismatch: expected %0d actual %0d",
                   heading_queue[0], out_heading);
            failed = 1'b1;
          end
          void'(heading_queue.pop_front());
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("compass_heading_atan2_unit_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_send [4];
    int unsigned phase_recv [4];
    int          p, n;
    phase_send = '{0, 49, 0, 23};
    phase_recv = '{0, 0, 49, 23};
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_x_field     = '0;
    in_y_field     = '0;
    out_ready      = 1'b0;
    presenting     = 1'b0;
    failed         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: zero vector, axes, extremes, all four quadrants,
    // both pre-rotation branches and the wrap from a full turn to zero.
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(0, 32767);
    queue_sample(-32768, 0);
    queue_sample(0, -32768);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, -1);
    queue_sample(100, -1);
    queue_sample(1, 0);
    queue_sample(0, 1);
    queue_sample(-1, 0);
    queue_sample(0, -1);
    queue_sample(1, 1);
    queue_sample(-1, 1);
    queue_sample(-1, -1);
    queue_sample(1, -1);
    queue_sample(-32768, -1);
    queue_sample(-32768, 1);
    queue_sample(-1, -32768);
    queue_sample(-5, 0);
    queue_sample(-21846, 21845);

    for (p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      for (n = 0; n < 175; n++) queue_random_sample();
      while (sample_queue.size() != 0 || heading_queue.size() != 0)
        @(posedge clk);
    end

    repeat (40) @(posedge clk);
    if (heading_queue.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("compass_heading_atan2_unit_tb: PASS");
    end else begin
      $display("compass_heading_atan2_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/chdg_pkg.sv
rtl/chdg_prerot.sv
rtl/chdg_cordic_stage.sv
rtl/chdg_round.sv
rtl/compass_heading_atan2_unit.sv
tb/compass_heading_atan2_unit_tb.sv
